[rtl/ptq_pkg.sv]
// ptq_pkg: shared types, sizes and codes for the priority task queue.
// Used by ptq_store and priority_task_queue; depends on nothing.
package ptq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int OCC_W       = 5;

   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic        operation;
      logic [7:0]  task_priority;
      logic [15:0] task_ident;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [7:0]       out_priority;
      logic [15:0]      out_ident;
      logic [OCC_W-1:0] occupancy;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  prio;
      logic [15:0] ident;
   } entry_type;

   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_idx;
      logic             rm_en;
      logic [IDX_W-1:0] rm_idx;
      logic [IDX_W-1:0] rd_idx;
   } store_ctrl_type;

endpackage

[rtl/ptq_store.sv]
// ptq_store: task entry storage with tail write, indexed read and remove-and-compact.
// Depends on ptq_pkg.
module ptq_store (
   input  logic                      clock,
   input  ptq_pkg::store_ctrl_type   ctrl,
   input  ptq_pkg::entry_type        wr_data,
   output ptq_pkg::entry_type        rd_data,
   output ptq_pkg::entry_type        head_data
);

   ptq_pkg::entry_type entry_ff [ptq_pkg::QUEUE_DEPTH];

   // Remove: every entry from the removed slot up to the one below the top takes its upper neighbor.
   always_ff @(posedge clock) begin
      if (ctrl.rm_en) begin
         for (int i = 0; i < ptq_pkg::QUEUE_DEPTH - 1; i++) begin
            if (ptq_pkg::IDX_W'(i) >= ctrl.rm_idx) begin
               entry_ff[i] <= entry_ff[i + 1];
            end
         end
      end else if (ctrl.wr_en) begin
         entry_ff[ctrl.wr_idx] <= wr_data;
      end
   end

   assign rd_data   = entry_ff[ctrl.rd_idx];
   assign head_data = entry_ff[0];

endmodule

[rtl/priority_task_queue.sv]
// priority_task_queue: bounded task queue served by highest priority, linear scan.
// Depends on ptq_pkg and ptq_store.
//
// Usage:
//   req channel (req_valid/req_ready/req_data) carries one beat per operation:
//   enqueue appends (task_priority, task_ident) at the tail; dequeue removes the
//   highest-priority task, oldest first among equals, and keeps arrival order.
//   rsp channel (rsp_valid/rsp_ready/rsp_data) returns exactly one beat per
//   request: status (ok, full, empty), the dequeued task or zeros, and the
//   number of tasks held afterward.
// Sequence:
//   One shared 8-bit comparator walks the stored entries one per cycle.
//   Enqueue and failed operations: accept, then hand-off; the result is
//   registered from the hand-off state.
//   Dequeue of N held tasks: accept, scan of entries 1..N-1, a remove step that
//   compacts all later entries at once, then hand-off; the result is registered
//   from the hand-off state.
//   The block takes one request at a time; req_ready is high only when idle.
// Reset and stalls:
//   Synchronous reset empties the queue and drops any pending response; entry
//   contents are not cleared. While the output register holds an untaken beat,
//   the result waits in hand-off and a new request is taken once it frees.
module priority_task_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ptq_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ptq_pkg::rsp_type  rsp_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_REMOVE = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic [ptq_pkg::CNT_W-1:0]   count_ff, count_in;
   logic [ptq_pkg::IDX_W-1:0]   scan_idx_ff, scan_idx_in;
   logic [ptq_pkg::IDX_W-1:0]   best_idx_ff, best_idx_in;
   ptq_pkg::entry_type          best_ff, best_in;
   ptq_pkg::rsp_type            res_ff, res_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   ptq_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   ptq_pkg::store_ctrl_type     store_ctrl;
   ptq_pkg::entry_type          wr_data;
   ptq_pkg::entry_type          rd_data;
   ptq_pkg::entry_type          head_data;

   logic                        is_full;
   logic                        is_empty;
   logic                        out_free;
   logic [ptq_pkg::IDX_W-1:0]   last_idx;

   ptq_store u_store (
      .clock     (clock),
      .ctrl      (store_ctrl),
      .wr_data   (wr_data),
      .rd_data   (rd_data),
      .head_data (head_data)
   );

   assign is_full   = (count_ff == ptq_pkg::CNT_W'(ptq_pkg::QUEUE_DEPTH));
   assign is_empty  = (count_ff == '0);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign last_idx  = ptq_pkg::IDX_W'(count_ff - ptq_pkg::CNT_W'(1));
   assign req_ready = (state_ff == ST_IDLE);
   assign wr_data   = '{prio: req_data.task_priority, ident: req_data.task_ident};

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      scan_idx_in = scan_idx_ff;
      best_idx_in = best_idx_ff;
      best_in     = best_ff;
      res_in      = res_ff;
      store_ctrl  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.operation == ptq_pkg::OP_ENQUEUE) begin
                  if (is_full) begin
                     // Drop the task, report full.
                     res_in = '{status: ptq_pkg::STATUS_FULL, out_priority: '0,
                                out_ident: '0,
                                occupancy: ptq_pkg::OCC_W'(count_ff)};
                  end else begin
                     store_ctrl.wr_en  = 1'b1;
                     store_ctrl.wr_idx = ptq_pkg::IDX_W'(count_ff);
                     count_in          = count_ff + ptq_pkg::CNT_W'(1);
                     res_in = '{status: ptq_pkg::STATUS_OK, out_priority: '0,
                                out_ident: '0,
                                occupancy: ptq_pkg::OCC_W'(count_ff + ptq_pkg::CNT_W'(1))};
                  end
                  state_in = ST_DONE;
               end else if (is_empty) begin
                  res_in = '{status: ptq_pkg::STATUS_EMPTY, out_priority: '0,
                             out_ident: '0, occupancy: '0};
                  state_in = ST_DONE;
               end else begin
                  // Seed the scan with the oldest entry.
                  best_idx_in = '0;
                  best_in     = head_data;
                  scan_idx_in = ptq_pkg::IDX_W'(1);
                  state_in    = (last_idx == '0) ? ST_REMOVE : ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // One entry per cycle; strict greater keeps the oldest on ties.
            store_ctrl.rd_idx = scan_idx_ff;
            if (rd_data.prio > best_ff.prio) begin
               best_idx_in = scan_idx_ff;
               best_in     = rd_data;
            end
            if (scan_idx_ff == last_idx) begin
               state_in = ST_REMOVE;
            end else begin
               scan_idx_in = scan_idx_ff + ptq_pkg::IDX_W'(1);
            end
         end

         ST_REMOVE: begin
            // Compact the later entries down by one, all at once.
            store_ctrl.rm_en  = 1'b1;
            store_ctrl.rm_idx = best_idx_ff;
            count_in          = count_ff - ptq_pkg::CNT_W'(1);
            res_in = '{status: ptq_pkg::STATUS_OK, out_priority: best_ff.prio,
                       out_ident: best_ff.ident,
                       occupancy: ptq_pkg::OCC_W'(count_ff - ptq_pkg::CNT_W'(1))};
            state_in = ST_DONE;
         end

         ST_DONE: begin
            // Hold until the output register can take the result.
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (state_ff == ST_DONE && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Occupancy never passes the queue depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= ptq_pkg::CNT_W'(ptq_pkg::QUEUE_DEPTH))
      else $error("task count above queue depth");

   // The scan pointer stays inside the held entries.
   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (ptq_pkg::CNT_W'(scan_idx_ff) < count_ff))
      else $error("scan index beyond held tasks");

   // An accepted enqueue into a non-full queue grows the count by one.
   a_enqueue_grows: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_data.operation == ptq_pkg::OP_ENQUEUE && !is_full)
      |=> (count_ff == $past(count_ff) + ptq_pkg::CNT_W'(1)))
      else $error("enqueue did not advance count");

   // A remove cycle always hands off a successful result next.
   a_remove_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REMOVE) |=> (state_ff == ST_DONE && res_ff.status == ptq_pkg::STATUS_OK))
      else $error("remove did not produce ok result");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking testbench for priority_task_queue (enqueue/dequeue by priority).
// Depends on ptq_pkg for the beat types, sizes and codes; needs only the RTL.

module tb;

   localparam int RANDOM_PER_PHASE = 275;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES    = ptq_pkg::QUEUE_DEPTH + 4;
   localparam int DIRECTED_ROWS    = 25;

   // One row of directed stimulus: the request beat, whether its answer is
   // spelled out here, and that answer. Rows left open go to the shadow queue.
   typedef struct packed {
      ptq_pkg::req_type    item;
      logic                typed;
      ptq_pkg::rsp_type    want;
   } stim_row_type;

   localparam logic [31:0] UNTYPED = '0;

   // Walk: empty dequeue, extreme priorities and idents, a tie at the top
   // priority, fill to the limit with ties, enqueue into the full queue,
   // then a dequeue and refill at the boundary.
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      {ptq_pkg::OP_DEQUEUE, 8'hFF, 16'hFFFF, 1'b1, ptq_pkg::STATUS_EMPTY, 8'h00, 16'h0000, 5'd0},
      {ptq_pkg::OP_ENQUEUE, 8'h00, 16'h0000, 1'b1, ptq_pkg::STATUS_OK,    8'h00, 16'h0000, 5'd1},
      {ptq_pkg::OP_ENQUEUE, 8'hFF, 16'hFFFF, 1'b1, ptq_pkg::STATUS_OK,    8'h00, 16'h0000, 5'd2},
      {ptq_pkg::OP_ENQUEUE, 8'h80, 16'h1234, UNTYPED},
      {ptq_pkg::OP_ENQUEUE, 8'hFF, 16'h0001, UNTYPED},
      {ptq_pkg::OP_DEQUEUE, 8'h00, 16'h0000, 1'b1, ptq_pkg::STATUS_OK,    8'hFF, 16'hFFFF, 5'd3},
      {ptq_pkg::OP_DEQUEUE, 8'h00, 16'h0000, 1'b1, ptq_pkg::STATUS_OK,    8'hFF, 16'h0001, 5'd2},
      {ptq_pkg::OP_ENQUEUE, 8'h55, 16'hAAAA, UNTYPED},
      {ptq_pkg::OP_ENQUEUE, 8'h55, 16'h5555, UNTYPED},
      {ptq_pkg::OP_ENQUEUE, 8'h01, 16'h8000, UNTYPED},
      {ptq_pkg::OP_ENQUEUE, 8'hFE, 16'h7FFF, UNTYPED},
      {ptq_pkg::OP_ENQUEUE, 8'h55, 16'h0F0F, UNTYPED},
      {ptq_pkg::OP_ENQUEUE, 8'h7F, 16'hF0F0, UNTYPED},
      {ptq_pkg::OP_ENQUEUE, 8'h80, 16'h00FF, UNTYPED},
      {ptq_pkg::OP_ENQUEUE, 8'hFE, 16'hFF00, UNTYPED},
      {ptq_pkg::OP_ENQUEUE, 8'h00, 16'h3333, UNTYPED},
      {ptq_pkg::OP_ENQUEUE, 8'hAA, 16'hCCCC, UNTYPED},
      {ptq_pkg::OP_ENQUEUE, 8'h55, 16'h1111, UNTYPED},
      {ptq_pkg::OP_ENQUEUE, 8'h02, 16'h2222, UNTYPED},
      {ptq_pkg::OP_ENQUEUE, 8'hFE, 16'h4444, UNTYPED},
      {ptq_pkg::OP_ENQUEUE, 8'h40, 16'h8888, UNTYPED},
      {ptq_pkg::OP_ENQUEUE, 8'hAA, 16'h5555, 1'b1, ptq_pkg::STATUS_FULL,  8'h00, 16'h0000, 5'd16},
      {ptq_pkg::OP_DEQUEUE, 8'hC3, 16'h3C3C, UNTYPED},
      {ptq_pkg::OP_ENQUEUE, 8'h3C, 16'hC3C3, UNTYPED},
      {ptq_pkg::OP_DEQUEUE, 8'h00, 16'h0000, UNTYPED}
   };

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   ptq_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   ptq_pkg::rsp_type rsp_data;

   // Shadow copy of the task store, advanced once per accepted request beat.
   logic [7:0]  shadow_prio  [ptq_pkg::QUEUE_DEPTH];
   logic [15:0] shadow_ident [ptq_pkg::QUEUE_DEPTH];
   int          shadow_count;

   stim_row_type     row_notes [$];     // one note per request beat still to be taken
   ptq_pkg::rsp_type awaited_rsp [$];   // answers the block still owes, oldest first

   int error_count;
   int send_idle_pct;
   int recv_idle_pct;
   bit long_hold_req;

   int enq_beats, deq_beats, full_hits, empty_hits, peak_count;

   stim_row_type     note;
   ptq_pkg::rsp_type predicted;
   ptq_pkg::rsp_type want;

   priority_task_queue dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      reset <= 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
   end

   // Apply one request to the shadow queue and return the answer it owes.
   // Dequeue picks the first entry holding the largest priority, then closes
   // the gap so that arrival order among the rest is kept.
   function automatic ptq_pkg::rsp_type serve_shadow_queue(input ptq_pkg::req_type item);
      ptq_pkg::rsp_type r;
      int               best;
      int               i;
      r = '0;
      r.status = ptq_pkg::STATUS_OK;
      if (item.operation == ptq_pkg::OP_ENQUEUE) begin
         if (shadow_count >= ptq_pkg::QUEUE_DEPTH) begin
            r.status = ptq_pkg::STATUS_FULL;
         end else begin
            shadow_prio[shadow_count]  = item.task_priority;
            shadow_ident[shadow_count] = item.task_ident;
            shadow_count++;
         end
      end else if (shadow_count == 0) begin
         r.status = ptq_pkg::STATUS_EMPTY;
      end else begin
         best = 0;
         for (i = 1; i < shadow_count; i++) begin
            if (shadow_prio[i] > shadow_prio[best])
               best = i;
         end
         r.out_priority = shadow_prio[best];
         r.out_ident    = shadow_ident[best];
         for (i = best; i + 1 < shadow_count; i++) begin
            shadow_prio[i]  = shadow_prio[i + 1];
            shadow_ident[i] = shadow_ident[i + 1];
         end
         shadow_count--;
      end
      r.occupancy = ptq_pkg::OCC_W'(shadow_count);
      return r;
   endfunction

   task automatic check_field(input string field, input int expected, input int actual);
      if (expected != actual) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d",
                  $time, field, expected, actual);
      end
   endtask

   // Offer one request beat: idle at random first, then hold valid and the
   // payload steady until the block takes the beat.
   task automatic drive_request(input ptq_pkg::req_type item);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
   endtask

   // Monitor: sample both channels at the edge. Every accepted request beat
   // advances the shadow queue; every accepted response beat is matched
   // against the oldest owed answer.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            note      = row_notes.pop_front();
            predicted = serve_shadow_queue(req_data);
            awaited_rsp.push_back(note.typed ? note.want : predicted);
            if (req_data.operation == ptq_pkg::OP_ENQUEUE) enq_beats++;
            else deq_beats++;
            if (predicted.status == ptq_pkg::STATUS_FULL) full_hits++;
            if (predicted.status == ptq_pkg::STATUS_EMPTY) empty_hits++;
            if (shadow_count > peak_count) peak_count = shadow_count;
         end
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               error_count++;
               $display("%0t: response beat with nothing owed, expected none, actual %h",
                        $time, rsp_data);
            end else begin
               want = awaited_rsp.pop_front();
               check_field("status",       want.status,       rsp_data.status);
               check_field("out_priority", want.out_priority, rsp_data.out_priority);
               check_field("out_ident",    want.out_ident,    rsp_data.out_ident);
               check_field("occupancy",    want.occupancy,    rsp_data.occupancy);
            end
         end
      end
   end

   // Receiver: drop ready at random, or hold it low for a long stretch on
   // request so the block finishes a beat, parks it and stalls its input.
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES - 1) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   // Sender: directed table first, then random bursts in three idling phases.
   initial begin
      ptq_pkg::req_type item;
      int               row;
      int               phase;
      int               sent;
      int               burst_len;
      int               burst_kind;
      int               prio_mode;
      int               k;

      req_valid     <= 1'b0;
      req_data      <= '0;
      error_count   = 0;
      shadow_count  = 0;
      long_hold_req = 1'b0;
      send_idle_pct = 8;
      recv_idle_pct = 78;
      enq_beats = 0; deq_beats = 0; full_hits = 0; empty_hits = 0; peak_count = 0;

      @(posedge clock);
      while (reset)
         @(posedge clock);

      for (row = 0; row < DIRECTED_ROWS; row++) begin
         row_notes.push_back(DIRECTED[row]);
         drive_request(DIRECTED[row].item);
      end

      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 8;
               recv_idle_pct = 78;
            end
            1: begin
               send_idle_pct = 78;
               recv_idle_pct = 8;
            end
            default: begin
               // Back-to-back traffic; open with a long receiver stall.
               send_idle_pct = 0;
               recv_idle_pct = 0;
               long_hold_req = 1'b1;
            end
         endcase
         sent = 0;
         while (sent < RANDOM_PER_PHASE) begin
            // Enqueue runs and dequeue runs walk the queue between empty and
            // full; a few mixed runs add noise around wherever it stands.
            burst_kind = $urandom_range(0, 9);
            burst_len  = (burst_kind < 5) ? $urandom_range(1, 24) : $urandom_range(1, 20);
            prio_mode  = $urandom_range(0, 2);
            for (k = 0; k < burst_len && sent < RANDOM_PER_PHASE; k++) begin
               if (burst_kind < 5)
                  item.operation = ptq_pkg::OP_ENQUEUE;
               else if (burst_kind < 9)
                  item.operation = ptq_pkg::OP_DEQUEUE;
               else
                  item.operation = 1'($urandom_range(0, 1));
               case (prio_mode)
                  0: item.task_priority = 8'($urandom_range(0, 255));
                  1: item.task_priority = 8'($urandom_range(0, 3));   // force ties
                  default: begin
                     case ($urandom_range(0, 3))
                        0: item.task_priority = 8'h00;
                        1: item.task_priority = 8'h01;
                        2: item.task_priority = 8'hFE;
                        default: item.task_priority = 8'hFF;
                     endcase
                  end
               endcase
               item.task_ident = 16'($urandom_range(0, 65535));
               row_notes.push_back({item, UNTYPED});
               drive_request(item);
               sent++;
            end
         end
      end
      req_valid <= 1'b0;

      // Drain: wait for every owed answer, then let stray beats show up.
      while (awaited_rsp.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Ran %0d enqueue and %0d dequeue beats; %0d hit a full queue, %0d an empty one.",
               enq_beats, deq_beats, full_hits, empty_hits);
      $display("Peak occupancy %0d of %0d, with a %0d-cycle receiver stall.",
               peak_count, ptq_pkg::QUEUE_DEPTH, LONG_HOLD_CYCLES);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #2000000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
